// ===== hw/rtl/cbr_pkg.sv =====
// Shared types and constants for the cubic bisection root finder.
package cbr_pkg;

	localparam int DATA_W = 32;
	localparam int TOL_W  = 31;
	localparam int ITER_W = 6;
	localparam int ADDR_W = 4;

	// register index, taken from paddr[3:2]
	localparam logic [1:0] REG_COEF_CONST  = 2'd0;
	localparam logic [1:0] REG_COEF_LINEAR = 2'd1;
	localparam logic [1:0] REG_COEF_SQUARE = 2'd2;
	localparam logic [1:0] REG_COEF_CUBE   = 2'd3;

	typedef struct packed {
		logic signed [DATA_W-1:0] lower_bound;
		logic signed [DATA_W-1:0] upper_bound;
		logic        [TOL_W-1:0]  tolerance;
	} in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] root;
		logic        [ITER_W-1:0] iterations;
		logic                     no_sign_change;
		logic                     hit_limit;
	} out_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] c0;
		logic signed [DATA_W-1:0] c1;
		logic signed [DATA_W-1:0] c2;
		logic signed [DATA_W-1:0] c3;
	} coef_t;

	typedef struct packed {
		logic busy;
		logic done;
	} eval_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EVAL_A,
		ST_EVAL_B,
		ST_EVAL_M,
		ST_CHECK,
		ST_DONE
	} state_t;

endpackage

// ===== hw/rtl/cbr_cfg.sv =====
// APB register file holding the four cubic coefficients.
module cbr_cfg
	import cbr_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready,
	output coef_t             coef
);

	coef_t      coef_q;
	logic       wr_en;
	logic [1:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[3:2];
	assign coef    = coef_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q <= '0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_COEF_CONST:  coef_q.c0 <= pwdata;
				REG_COEF_LINEAR: coef_q.c1 <= pwdata;
				REG_COEF_SQUARE: coef_q.c2 <= pwdata;
				REG_COEF_CUBE:   coef_q.c3 <= pwdata;
				default:         coef_q    <= coef_q;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_COEF_CONST:  prdata = coef_q.c0;
			REG_COEF_LINEAR: prdata = coef_q.c1;
			REG_COEF_SQUARE: prdata = coef_q.c2;
			REG_COEF_CUBE:   prdata = coef_q.c3;
			default:         prdata = '0;
		endcase
	end

endmodule

// ===== hw/rtl/cbr_horner.sv =====
// Horner evaluator for the cubic on one shared 32x32 multiplier.
module cbr_horner
	import cbr_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	input  logic signed [DATA_W-1:0] x,
	input  coef_t                    coef,
	output eval_stat_t               stat,
	output logic signed [DATA_W-1:0] y
);

	localparam int PROD_W = 2 * DATA_W;

	logic                     run_q;
	logic                     done_q;
	logic                     mul_done_q;
	logic [1:0]               term_q;
	logic signed [DATA_W-1:0] x_q;
	logic signed [DATA_W-1:0] acc_q;
	logic signed [PROD_W-1:0] prod_s1;
	logic signed [PROD_W-1:0] prod_shr;
	logic signed [DATA_W-1:0] addend;
	logic        [PROD_W:0]   sum;
	logic signed [DATA_W-1:0] sum_sat;
	logic                     sat_hi;
	logic                     sat_lo;

	always_comb begin
		unique case (term_q)
			2'd0:    addend = coef.c2;
			2'd1:    addend = coef.c1;
			default: addend = coef.c0;
		endcase
	end

	// arithmetic shift gives the floor
	assign prod_shr = prod_s1 >>> FRAC_BITS;
	assign sum      = {prod_shr[PROD_W-1], prod_shr} +
	                  {{(PROD_W-DATA_W+1){addend[DATA_W-1]}}, addend};
	assign sat_lo   = sum[PROD_W] & ~(&sum[PROD_W-1:DATA_W-1]);
	assign sat_hi   = ~sum[PROD_W] & (|sum[PROD_W-1:DATA_W-1]);

	always_comb begin
		if (sat_hi) begin
			sum_sat = {1'b0, {(DATA_W-1){1'b1}}};
		end else if (sat_lo) begin
			sum_sat = {1'b1, {(DATA_W-1){1'b0}}};
		end else begin
			sum_sat = sum[DATA_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q      <= 1'b0;
			done_q     <= 1'b0;
			mul_done_q <= 1'b0;
			term_q     <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q      <= 1'b1;
				mul_done_q <= 1'b0;
				term_q     <= '0;
			end else if (run_q) begin
				mul_done_q <= ~mul_done_q;
				if (mul_done_q) begin
					term_q <= term_q + 2'd1;
					if (term_q == 2'd2) begin
						run_q  <= 1'b0;
						done_q <= 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= x;
			acc_q <= coef.c3;
		end else if (run_q) begin
			if (!mul_done_q) begin
				prod_s1 <= acc_q * x_q;
			end else begin
				acc_q <= sum_sat;
			end
		end
	end

	assign stat.busy = run_q;
	assign stat.done = done_q;
	assign y         = acc_q;

endmodule

// ===== hw/rtl/cubic_bisection_root_core.sv =====
// Top level: bisection sequencer around the cubic evaluator and coefficient registers.
//
//  channel | direction | handshake          | word
//  in      | into core | in_valid/in_stall   | in_t: lower_bound, upper_bound, tolerance
//  out     | from core | out_valid/out_stall | out_t: root, iterations, flags
//  cfg     | into core | APB psel/penable    | coefficients c0..c3 at 0x0..0xC
//
// One cubic evaluation runs three multiply/add pairs on the shared multiplier.
// The input is stalled from acceptance until the result is placed in the output register.
// A result waiting on out_stall does not block the next input word.
// Reset clears control state and the coefficients to zero.
module cubic_bisection_root_core
	import cbr_pkg::*;
#(
	parameter int MAX_ITER  = 32,
	parameter int FRAC_BITS = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_stall,
	input  in_t               in_data,
	output logic              out_valid,
	input  logic              out_stall,
	output out_t              out_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	localparam int CNT_W = $clog2(MAX_ITER + 1);

	coef_t                    coef;
	eval_stat_t               ev_stat;
	logic signed [DATA_W-1:0] ev_y;
	logic                     ev_start;
	logic signed [DATA_W-1:0] ev_x;

	state_t                   state_q;
	state_t                   state_nx;

	logic signed [DATA_W-1:0] a_q;
	logic signed [DATA_W-1:0] b_q;
	logic signed [DATA_W-1:0] mid_q;
	logic        [TOL_W-1:0]  tol_q;
	logic        [CNT_W-1:0]  cnt_q;
	logic                     ya_pos_q;
	logic                     ya_neg_q;
	logic                     yb_pos_q;
	logic                     yb_neg_q;
	logic                     zero_q;
	logic                     nsc_q;
	logic                     capped_q;
	logic                     out_valid_q;
	out_t                     out_q;

	logic                     in_acc;
	logic                     ld_ya;
	logic                     ld_yb;
	logic                     ld_step;
	logic                     ld_out;
	logic                     chk_stop;

	logic        [DATA_W:0]   ab_sum;
	logic signed [DATA_W-1:0] mid_nx;
	logic                     y_pos;
	logic                     y_neg;
	logic        [DATA_W:0]   diff;
	logic        [DATA_W:0]   width;
	logic                     in_tol;
	logic                     at_cap;
	logic [CNT_W+ITER_W-1:0]  cnt_ext;

	cbr_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.coef    (coef)
	);

	cbr_horner #(
		.FRAC_BITS (FRAC_BITS)
	) u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ev_start),
		.x      (ev_x),
		.coef   (coef),
		.stat   (ev_stat),
		.y      (ev_y)
	);

	// datapath terms
	assign ab_sum = {a_q[DATA_W-1], a_q} + {b_q[DATA_W-1], b_q};
	assign mid_nx = ab_sum[DATA_W:1];
	assign y_pos  = ~ev_y[DATA_W-1] & (|ev_y);
	assign y_neg  = ev_y[DATA_W-1];
	assign diff   = {b_q[DATA_W-1], b_q} - {a_q[DATA_W-1], a_q};
	assign width  = diff[DATA_W] ? (~diff + 1'b1) : diff;
	assign in_tol = width <= {{(DATA_W+1-TOL_W){1'b0}}, tol_q};
	assign at_cap = cnt_q >= CNT_W'(MAX_ITER);
	assign chk_stop = zero_q | in_tol | at_cap;
	assign cnt_ext  = {{ITER_W{1'b0}}, cnt_q};

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			ST_IDLE:   if (in_valid) state_nx = ST_EVAL_A;
			ST_EVAL_A: if (ev_stat.done) state_nx = ST_EVAL_B;
			ST_EVAL_B: if (ev_stat.done) state_nx = ST_EVAL_M;
			ST_EVAL_M: if (ev_stat.done) state_nx = ST_CHECK;
			ST_CHECK:  state_nx = chk_stop ? ST_DONE : ST_EVAL_M;
			ST_DONE:   if (!out_valid_q || !out_stall) state_nx = ST_IDLE;
			default:   state_nx = ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		in_acc   = 1'b0;
		ld_ya    = 1'b0;
		ld_yb    = 1'b0;
		ld_step  = 1'b0;
		ld_out   = 1'b0;
		ev_start = 1'b0;
		ev_x     = b_q;
		unique case (state_q)
			ST_IDLE: begin
				in_acc   = in_valid;
				ev_start = in_valid;
				ev_x     = in_data.lower_bound;
			end
			ST_EVAL_A: begin
				ld_ya    = ev_stat.done;
				ev_start = ev_stat.done;
				ev_x     = b_q;
			end
			ST_EVAL_B: begin
				ld_yb    = ev_stat.done;
				ev_start = ev_stat.done;
				ev_x     = mid_nx;
			end
			ST_EVAL_M: begin
				ld_step = ev_stat.done;
			end
			ST_CHECK: begin
				ev_start = ~chk_stop;
				ev_x     = mid_nx;
			end
			ST_DONE: begin
				ld_out = ~out_valid_q | ~out_stall;
			end
			default: begin
				ev_start = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ld_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			a_q   <= in_data.lower_bound;
			b_q   <= in_data.upper_bound;
			tol_q <= in_data.tolerance;
			cnt_q <= '0;
		end
		if (ld_ya) begin
			ya_pos_q <= y_pos;
			ya_neg_q <= y_neg;
		end
		if (ld_yb) begin
			yb_pos_q <= y_pos;
			yb_neg_q <= y_neg;
			nsc_q    <= ~((ya_neg_q & y_pos) | (ya_pos_q & y_neg));
		end
		if (ev_start && (state_q == ST_EVAL_B || state_q == ST_CHECK)) begin
			mid_q <= mid_nx;
		end
		if (ld_step) begin
			// an end whose value shares the midpoint's strict sign moves in
			if ((y_pos && ya_pos_q) || (y_neg && ya_neg_q)) a_q <= mid_q;
			if ((y_pos && yb_pos_q) || (y_neg && yb_neg_q)) b_q <= mid_q;
			cnt_q  <= cnt_q + CNT_W'(1);
			zero_q <= ~(|ev_y);
		end
		if (state_q == ST_CHECK) begin
			capped_q <= ~zero_q & ~in_tol;
		end
		if (ld_out) begin
			out_q.root           <= mid_q;
			out_q.iterations     <= cnt_ext[ITER_W-1:0];
			out_q.no_sign_change <= nsc_q;
			out_q.hit_limit      <= capped_q;
		end
	end

	assign in_stall  = (state_q != ST_IDLE);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		ev_start |-> (!ev_stat.busy || ev_stat.done))
		else $error("evaluator restarted mid-evaluation");

	a_done_in_eval: assert property (@(posedge clk) disable iff (!arst_n)
		ev_stat.done |-> (state_q == ST_EVAL_A || state_q == ST_EVAL_B ||
		                  state_q == ST_EVAL_M))
		else $error("evaluation finished outside an evaluation state");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CHECK || state_q == ST_DONE) |->
		(cnt_q != '0 && cnt_q <= CNT_W'(MAX_ITER)))
		else $error("step count out of range");

	a_cap_count: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) && out_q.hit_limit |->
		out_q.iterations == ITER_W'(MAX_ITER))
		else $error("cap flagged below the step limit");

endmodule

// ===== tb/tb_cubic_bisection_root_core.sv =====
// Self-checking testbench for the cubic bisection root finder core.
module tb_cubic_bisection_root_core;
	import cbr_pkg::*;

	localparam int MAX_ITER  = 32;
	localparam int FRAC_BITS = 16;
	localparam int CYCLE_LIMIT = 3_000_000;

	localparam logic signed [DATA_W-1:0] Q_ONE = 32'sd65536;
	localparam logic signed [DATA_W-1:0] Q_MAX = 32'sh7FFFFFFF;
	localparam logic signed [DATA_W-1:0] Q_MIN = 32'sh80000000;
	localparam logic signed [63:0] SAT_HI = 64'sd2147483647;
	localparam logic signed [63:0] SAT_LO = -64'sd2147483648;

	typedef enum int {COEF_CLASSIC, COEF_SMALL, COEF_WIDE, COEF_CORNER, COEF_ZERO} coef_kind_t;

	logic              clk;
	logic              arst_n;
	logic              in_valid;
	logic              in_stall;
	in_t               in_data;
	logic              out_valid;
	logic              out_stall;
	out_t              out_data;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	// local copy of the coefficient registers, indexed by register code
	logic signed [DATA_W-1:0] coef [4];
	out_t pending_roots [$];
	out_t want;
	int   fail_count;
	int   results_seen;
	int   cycles;
	int   stall_left;
	int   quiet_left;
	int   stall_pick;

	cubic_bisection_root_core #(
		.MAX_ITER (MAX_ITER),
		.FRAC_BITS(FRAC_BITS)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	task automatic report_fail(string msg);
		fail_count++;
		if (fail_count <= 10) begin
			$display("mismatch: %s", msg);
		end
	endtask

	// Horner evaluation with floor shift and saturation after every stage
	function automatic logic signed [DATA_W-1:0] cubic_at(logic signed [DATA_W-1:0] x);
		logic signed [63:0] acc;
		logic signed [63:0] xs;
		logic signed [63:0] ck;
		xs  = 64'(x);
		acc = 64'(coef[REG_COEF_CUBE]);
		for (int k = 2; k >= 0; k--) begin
			ck  = 64'(coef[k]);
			acc = ((acc * xs) >>> FRAC_BITS) + ck;
			if (acc > SAT_HI) begin
				acc = SAT_HI;
			end else if (acc < SAT_LO) begin
				acc = SAT_LO;
			end
		end
		return acc[DATA_W-1:0];
	endfunction

	function automatic out_t solve_bisection(in_t w);
		logic signed [63:0] a;
		logic signed [63:0] b;
		logic signed [63:0] mid;
		logic signed [63:0] width;
		logic signed [63:0] tol;
		logic signed [DATA_W-1:0] ya;
		logic signed [DATA_W-1:0] yb;
		logic signed [DATA_W-1:0] y;
		int   steps;
		bit   capped;
		bit   stop;
		out_t r;
		a      = 64'(w.lower_bound);
		b      = 64'(w.upper_bound);
		tol    = {33'b0, w.tolerance};
		ya     = cubic_at(w.lower_bound);
		yb     = cubic_at(w.upper_bound);
		steps  = 0;
		capped = 1'b0;
		stop   = 1'b0;
		mid    = '0;
		while (!stop) begin
			mid = (a + b) >>> 1;
			y   = cubic_at(mid[DATA_W-1:0]);
			if ((y > 0 && ya > 0) || (y < 0 && ya < 0)) begin
				a = mid;
			end
			if ((y > 0 && yb > 0) || (y < 0 && yb < 0)) begin
				b = mid;
			end
			steps++;
			width = (b > a) ? b - a : a - b;
			// zero test and width test rank together, both ahead of the cap
			if (y == 0 || width <= tol) begin
				stop = 1'b1;
			end else if (steps >= MAX_ITER) begin
				capped = 1'b1;
				stop   = 1'b1;
			end
		end
		r.root           = mid[DATA_W-1:0];
		r.iterations     = steps[ITER_W-1:0];
		r.no_sign_change = !((ya < 0 && yb > 0) || (ya > 0 && yb < 0));
		r.hit_limit      = capped;
		return r;
	endfunction

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			results_seen++;
			if (pending_roots.size() == 0) begin
				report_fail($sformatf("result %0d arrived with nothing pending", results_seen));
			end else begin
				want = pending_roots.pop_front();
				if (out_data.root !== want.root) begin
					report_fail($sformatf("result %0d root exp %h got %h",
						results_seen, want.root, out_data.root));
				end
				if (out_data.iterations !== want.iterations) begin
					report_fail($sformatf("result %0d iterations exp %0d got %0d",
						results_seen, want.iterations, out_data.iterations));
				end
				if (out_data.no_sign_change !== want.no_sign_change) begin
					report_fail($sformatf("result %0d no_sign_change exp %b got %b",
						results_seen, want.no_sign_change, out_data.no_sign_change));
				end
				if (out_data.hit_limit !== want.hit_limit) begin
					report_fail($sformatf("result %0d hit_limit exp %b got %b",
						results_seen, want.hit_limit, out_data.hit_limit));
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// receiver back-pressure: quiet stretches, short stalls, the odd long one
	always @(negedge clk) begin
		if (quiet_left > 0) begin
			quiet_left--;
			out_stall <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else begin
			stall_pick = $urandom_range(0, 99);
			if (stall_pick < 3) begin
				quiet_left = $urandom_range(50, 400);
			end else if (stall_pick < 6) begin
				stall_left = $urandom_range(20, 80);
			end else if (stall_pick < 30) begin
				stall_left = $urandom_range(1, 3);
			end
			out_stall <= 1'b0;
		end
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60) begin
			return 0;
		end else if (r < 90) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 80);
	endfunction

	function automatic logic signed [DATA_W-1:0] pick_corner();
		case ($urandom_range(0, 6))
			0: begin
				return Q_MIN;
			end
			1: begin
				return Q_MAX;
			end
			2: begin
				return '0;
			end
			3: begin
				return -32'sd1;
			end
			4: begin
				return 32'sd1;
			end
			5: begin
				return Q_ONE;
			end
			default: begin
				return -Q_ONE;
			end
		endcase
	endfunction

	// uniform value in [-span, span] whole units, Q16.16
	function automatic logic signed [DATA_W-1:0] small_q(int span);
		int v;
		v = int'($urandom_range(0, 2 * span * 65536)) - span * 65536;
		return v;
	endfunction

	function automatic in_t gen_interval();
		in_t w;
		int  r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			w.lower_bound = small_q(16);
			w.upper_bound = small_q(16);
		end else if (r < 75) begin
			w.lower_bound = $urandom;
			w.upper_bound = $urandom;
		end else if (r < 85) begin
			w.lower_bound = pick_corner();
			w.upper_bound = pick_corner();
		end else if (r < 92) begin
			w.lower_bound = small_q(16);
			w.upper_bound = w.lower_bound;
		end else begin
			w.lower_bound = small_q(16);
			w.upper_bound = w.lower_bound + $signed(32'($urandom_range(0, 4096)));
		end
		r = $urandom_range(0, 99);
		if (r < 10) begin
			w.tolerance = '0;
		end else if (r < 55) begin
			w.tolerance = TOL_W'($urandom_range(0, 255));
		end else if (r < 80) begin
			w.tolerance = TOL_W'($urandom_range(0, 1 << 17));
		end else if (r < 92) begin
			w.tolerance = TOL_W'($urandom);
		end else begin
			w.tolerance = '1;
		end
		return w;
	endfunction

	task automatic send_word(in_t w, int gap);
		if (gap > 0) begin
			in_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid = 1'b1;
		in_data  = w;
		do @(posedge clk); while (in_stall);
		pending_roots.push_back(solve_bisection(w));
		@(negedge clk);
	endtask

	task automatic send_interval(logic signed [DATA_W-1:0] lo, logic signed [DATA_W-1:0] hi,
			logic [TOL_W-1:0] tol);
		in_t w;
		w.lower_bound = lo;
		w.upper_bound = hi;
		w.tolerance   = tol;
		send_word(w, pick_gap());
	endtask

	// hold the input off until every pending result has come back
	task automatic drain();
		in_valid = 1'b0;
		while (pending_roots.size() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic cfg_write(logic [1:0] idx, logic [DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {idx, 2'b00};
		pwdata  = value;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		coef[idx] = value;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
	endtask

	task automatic cfg_read(logic [1:0] idx, output logic [DATA_W-1:0] value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {idx, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		value = prdata;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic check_readback();
		logic [DATA_W-1:0] got;
		for (int i = 0; i < 4; i++) begin
			cfg_read(i[1:0], got);
			if (got !== coef[i]) begin
				report_fail($sformatf("register %0d read exp %h got %h", i, coef[i], got));
			end
		end
	endtask

	task automatic set_coefs(logic signed [DATA_W-1:0] c0, logic signed [DATA_W-1:0] c1,
			logic signed [DATA_W-1:0] c2, logic signed [DATA_W-1:0] c3);
		cfg_write(REG_COEF_CONST, c0);
		cfg_write(REG_COEF_LINEAR, c1);
		cfg_write(REG_COEF_SQUARE, c2);
		cfg_write(REG_COEF_CUBE, c3);
		check_readback();
	endtask

	task automatic test_registers();
		check_readback();
		set_coefs(Q_MAX, Q_MIN, 32'h5555AAAA, 32'hAAAA5555);
		set_coefs(Q_MIN, Q_MAX, 32'hAAAA5555, 32'h5555AAAA);
	endtask

	task automatic test_directed();
		// x^3 - 9x + 3
		set_coefs(3 * Q_ONE, -9 * Q_ONE, '0, Q_ONE);
		send_interval('0, Q_ONE, 31'h10);
		send_interval(Q_ONE, '0, 31'h10);
		send_interval(2 * Q_ONE, 2 * Q_ONE, '0);
		send_interval('0, Q_ONE, '1);
		send_interval(Q_MIN, Q_MAX, '0);
		send_interval(Q_MAX, Q_MIN, '0);
		send_interval('0, '0, '0);
		send_interval(-4 * Q_ONE, -3 * Q_ONE, '0);
		drain();
		// x^3 - x: roots at the ends and at the midpoint
		set_coefs('0, -Q_ONE, '0, Q_ONE);
		send_interval('0, 5 * Q_ONE, 31'h1);
		send_interval(-Q_ONE, Q_ONE, '0);
		send_interval(-2 * Q_ONE, Q_ONE / 2, 31'h4);
		drain();
		// plain x
		set_coefs('0, Q_ONE, '0, '0);
		send_interval(-3 * Q_ONE, 3 * Q_ONE, '0);
		send_interval(-Q_ONE, 2 * Q_ONE, '0);
		send_interval(3 * Q_ONE, 5 * Q_ONE, 31'h100);
		drain();
		// saturating evaluation
		set_coefs(Q_MAX, Q_MAX, Q_MAX, Q_MAX);
		send_interval(Q_MIN, Q_MAX, '0);
		send_interval(-Q_ONE, Q_ONE, 31'h20);
		drain();
		set_coefs(Q_MIN, Q_MIN, Q_MIN, Q_MIN);
		send_interval(Q_MAX, Q_MIN, '0);
		send_interval(-Q_ONE, Q_ONE, 31'h20);
		drain();
		// all-zero cubic: every point is a root
		set_coefs('0, '0, '0, '0);
		send_interval(Q_ONE, 2 * Q_ONE, '0);
		drain();
	endtask

	task automatic test_random_phase(coef_kind_t kind, int n_items);
		logic signed [DATA_W-1:0] c [4];
		bit steady;
		drain();
		for (int i = 0; i < 4; i++) begin
			case (kind)
				COEF_CLASSIC: begin
					c[i] = '0;
				end
				COEF_SMALL: begin
					c[i] = small_q(8);
				end
				COEF_WIDE: begin
					c[i] = $urandom;
				end
				COEF_CORNER: begin
					c[i] = pick_corner();
				end
				default: begin
					c[i] = '0;
				end
			endcase
		end
		if (kind == COEF_CLASSIC) begin
			c[REG_COEF_CONST]  = 3 * Q_ONE;
			c[REG_COEF_LINEAR] = -9 * Q_ONE;
			c[REG_COEF_CUBE]   = Q_ONE;
		end
		set_coefs(c[REG_COEF_CONST], c[REG_COEF_LINEAR], c[REG_COEF_SQUARE], c[REG_COEF_CUBE]);
		steady = 1'b0;
		for (int i = 0; i < n_items; i++) begin
			if (i % 50 == 0) begin
				steady = ($urandom_range(0, 3) == 0);
			end
			send_word(gen_interval(), steady ? 0 : pick_gap());
		end
	endtask

	initial begin
		clk          = 1'b0;
		arst_n       = 1'b0;
		in_valid     = 1'b0;
		in_data      = '0;
		out_stall    = 1'b0;
		psel         = 1'b0;
		penable      = 1'b0;
		pwrite       = 1'b0;
		paddr        = '0;
		pwdata       = '0;
		fail_count   = 0;
		results_seen = 0;
		cycles       = 0;
		stall_left   = 0;
		quiet_left   = 0;
		for (int i = 0; i < 4; i++) begin
			coef[i] = '0;
		end
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_registers();
		test_directed();
		test_random_phase(COEF_CLASSIC, 300);
		for (int p = 0; p < 4; p++) begin
			test_random_phase(COEF_SMALL, 150);
		end
		test_random_phase(COEF_WIDE, 150);
		test_random_phase(COEF_CORNER, 100);
		test_random_phase(COEF_ZERO, 50);
		test_random_phase(COEF_WIDE, 150);
		test_random_phase(COEF_CORNER, 100);
		test_random_phase(COEF_CLASSIC, 100);

		drain();
		repeat (300) @(posedge clk);
		if (pending_roots.size() != 0) begin
			report_fail($sformatf("%0d results never arrived", pending_roots.size()));
		end
		if (fail_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
